[hdl/aabi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabi_pkg: shared types and widths for the box iou pipeline
// Word formats on the box and iou channels, the word passed from the
// geometry stages to the divider, and the derived field widths.
// ----------------------------------------------------------------------------
package aabi_pkg;

  // field widths
  localparam int COORD_BITS      = 16;
  localparam int RATIO_FRAC_BITS = 16;

  // doubled edges: 2*centre +/- size, signed
  localparam int EDGE_W  = COORD_BITS + 2;
  // doubled intersection extent, unsigned
  localparam int EXT_W   = COORD_BITS + 1;
  // intersection area times four
  localparam int INTER_W = 2 * EXT_W;
  // sum of both box areas times four
  localparam int AREA_W  = 2 * COORD_BITS + 3;
  // ratio with one integer bit
  localparam int RATIO_W = RATIO_FRAC_BITS + 1;

  localparam logic [RATIO_W-1:0] RATIO_ONE = {1'b1, {RATIO_FRAC_BITS{1'b0}}};

  // input word: one pair of boxes
  typedef struct packed {
    logic signed [COORD_BITS-1:0] pred_center_x;
    logic signed [COORD_BITS-1:0] pred_center_y;
    logic        [COORD_BITS-1:0] pred_width;
    logic        [COORD_BITS-1:0] pred_height;
    logic signed [COORD_BITS-1:0] tgt_center_x;
    logic signed [COORD_BITS-1:0] tgt_center_y;
    logic        [COORD_BITS-1:0] tgt_width;
    logic        [COORD_BITS-1:0] tgt_height;
  } box_word_t;

  // output word: ratio and overlap flag
  typedef struct packed {
    logic [RATIO_W-1:0] iou_ratio;
    logic               boxes_overlap;
  } iou_word_t;

  // geometry result handed to the divider
  typedef struct packed {
    logic [INTER_W-1:0] inter;
    logic [AREA_W-1:0]  uni;
    logic               full;
    logic               ov;
  } geom_word_t;

endpackage

[hdl/aabi_geom.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabi_geom: box geometry pipeline
// Five register stages: doubled edges and box areas, intersection bounds,
// extents and overlap test, intersection area, union and full-ratio check.
// ----------------------------------------------------------------------------
module aabi_geom
  import aabi_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       box_valid,
  output logic       box_stall,
  input  box_word_t  box,
  output logic       geom_valid,
  input  logic       geom_stall,
  output geom_word_t geom
);

  localparam int NSTG = 5;

  typedef struct packed {
    logic signed [EDGE_W-1:0]   x1lo;
    logic signed [EDGE_W-1:0]   x1hi;
    logic signed [EDGE_W-1:0]   y1lo;
    logic signed [EDGE_W-1:0]   y1hi;
    logic signed [EDGE_W-1:0]   x2lo;
    logic signed [EDGE_W-1:0]   x2hi;
    logic signed [EDGE_W-1:0]   y2lo;
    logic signed [EDGE_W-1:0]   y2hi;
    logic [2*COORD_BITS-1:0]    a1;
    logic [2*COORD_BITS-1:0]    a2;
  } edge_word_t;

  typedef struct packed {
    logic signed [EDGE_W-1:0] ixlo;
    logic signed [EDGE_W-1:0] ixhi;
    logic signed [EDGE_W-1:0] iylo;
    logic signed [EDGE_W-1:0] iyhi;
    logic [AREA_W-1:0]        asum;
  } bound_word_t;

  typedef struct packed {
    logic [EXT_W-1:0]  ex;
    logic [EXT_W-1:0]  ey;
    logic              ov;
    logic [AREA_W-1:0] asum;
  } ext_word_t;

  typedef struct packed {
    logic [INTER_W-1:0] inter;
    logic               ov;
    logic [AREA_W-1:0]  asum;
  } prod_word_t;

  function automatic logic signed [EDGE_W-1:0] edge_lo(
    logic signed [COORD_BITS-1:0] c, logic [COORD_BITS-1:0] w);
    return $signed({c[COORD_BITS-1], c, 1'b0}) - $signed({2'b00, w});
  endfunction

  function automatic logic signed [EDGE_W-1:0] edge_hi(
    logic signed [COORD_BITS-1:0] c, logic [COORD_BITS-1:0] w);
    return $signed({c[COORD_BITS-1], c, 1'b0}) + $signed({2'b00, w});
  endfunction

  function automatic logic signed [EDGE_W-1:0] smax(
    logic signed [EDGE_W-1:0] a, logic signed [EDGE_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [EDGE_W-1:0] smin(
    logic signed [EDGE_W-1:0] a, logic signed [EDGE_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  logic        vld [NSTG];
  logic        rdy [NSTG+1];
  edge_word_t  s1;
  bound_word_t s2;
  ext_word_t   s3;
  prod_word_t  s4;
  geom_word_t  s5;

  logic signed [EDGE_W:0] dx;
  logic signed [EDGE_W:0] dy;
  logic                   ov3;
  logic [AREA_W-1:0]      inter_ext;
  logic [AREA_W-1:0]      uni5;

  // ready chain: a stage moves when it is empty or its successor moves
  assign rdy[NSTG] = !geom_stall;
  for (genvar k = 0; k < NSTG; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end

  assign box_stall  = !rdy[0];
  assign geom_valid = vld[NSTG-1];
  assign geom       = s5;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NSTG; k++) vld[k] <= 1'b0;
    end else begin
      if (rdy[0]) vld[0] <= box_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // stage 1: doubled edges and box areas
  always_ff @(posedge clk) begin
    if (rdy[0] && box_valid) begin
      s1.x1lo <= edge_lo(box.pred_center_x, box.pred_width);
      s1.x1hi <= edge_hi(box.pred_center_x, box.pred_width);
      s1.y1lo <= edge_lo(box.pred_center_y, box.pred_height);
      s1.y1hi <= edge_hi(box.pred_center_y, box.pred_height);
      s1.x2lo <= edge_lo(box.tgt_center_x, box.tgt_width);
      s1.x2hi <= edge_hi(box.tgt_center_x, box.tgt_width);
      s1.y2lo <= edge_lo(box.tgt_center_y, box.tgt_height);
      s1.y2hi <= edge_hi(box.tgt_center_y, box.tgt_height);
      s1.a1   <= box.pred_width * box.pred_height;
      s1.a2   <= box.tgt_width * box.tgt_height;
    end
  end

  // stage 2: intersection bounds and area sum times four
  always_ff @(posedge clk) begin
    if (rdy[1] && vld[0]) begin
      s2.ixlo <= smax(s1.x1lo, s1.x2lo);
      s2.ixhi <= smin(s1.x1hi, s1.x2hi);
      s2.iylo <= smax(s1.y1lo, s1.y2lo);
      s2.iyhi <= smin(s1.y1hi, s1.y2hi);
      s2.asum <= {({1'b0, s1.a1} + {1'b0, s1.a2}), 2'b00};
    end
  end

  // stage 3: extents, touching edges count as no overlap
  assign dx  = $signed({s2.ixhi[EDGE_W-1], s2.ixhi}) - $signed({s2.ixlo[EDGE_W-1], s2.ixlo});
  assign dy  = $signed({s2.iyhi[EDGE_W-1], s2.iyhi}) - $signed({s2.iylo[EDGE_W-1], s2.iylo});
  assign ov3 = ($signed(s2.ixhi) > $signed(s2.ixlo)) && ($signed(s2.iyhi) > $signed(s2.iylo));

  always_ff @(posedge clk) begin
    if (rdy[2] && vld[1]) begin
      s3.ex   <= ov3 ? dx[EXT_W-1:0] : '0;
      s3.ey   <= ov3 ? dy[EXT_W-1:0] : '0;
      s3.ov   <= ov3;
      s3.asum <= s2.asum;
    end
  end

  // stage 4: intersection area times four
  always_ff @(posedge clk) begin
    if (rdy[3] && vld[2]) begin
      s4.inter <= s3.ex * s3.ey;
      s4.ov    <= s3.ov;
      s4.asum  <= s3.asum;
    end
  end

  // stage 5: union and the ratio-of-one case
  assign inter_ext = {{(AREA_W-INTER_W){1'b0}}, s4.inter};
  assign uni5      = s4.asum - inter_ext;

  always_ff @(posedge clk) begin
    if (rdy[4] && vld[3]) begin
      s5.inter <= s4.inter;
      s5.uni   <= uni5;
      s5.full  <= s4.ov && (inter_ext >= uni5);
      s5.ov    <= s4.ov;
    end
  end

endmodule

[hdl/aabi_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabi_div: pipelined restoring divider
// One stage per quotient bit forms intersection / union as a fraction,
// then an output register applies the no-overlap and full-ratio cases.
// ----------------------------------------------------------------------------
module aabi_div
  import aabi_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       geom_valid,
  output logic       geom_stall,
  input  geom_word_t geom,
  output logic       iou_valid,
  input  logic       iou_stall,
  output iou_word_t  iou
);

  localparam int NSTEP = RATIO_FRAC_BITS;

  typedef struct packed {
    logic [AREA_W-1:0]          rem;
    logic [AREA_W-1:0]          uni;
    logic [RATIO_FRAC_BITS-1:0] quo;
    logic                       full;
    logic                       ov;
  } div_word_t;

  // one quotient bit: shift, compare, subtract
  function automatic div_word_t div_step(div_word_t d);
    logic [AREA_W:0] t;
    logic [AREA_W:0] u;
    div_word_t       r;
    r     = d;
    t     = {d.rem, 1'b0};
    u     = {1'b0, d.uni};
    r.quo = {d.quo[RATIO_FRAC_BITS-2:0], 1'b0};
    if (t >= u) begin
      t        = t - u;
      r.quo[0] = 1'b1;
    end
    r.rem = t[AREA_W-1:0];
    return r;
  endfunction

  div_word_t sin [NSTEP];
  logic      vin [NSTEP];
  div_word_t s   [NSTEP];
  logic      vld [NSTEP+1];
  logic      rdy [NSTEP+1];
  iou_word_t outw;

  // ready chain through the steps and the output register
  assign rdy[NSTEP] = !vld[NSTEP] || !iou_stall;
  for (genvar k = 0; k < NSTEP; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end

  assign geom_stall = !rdy[0];
  assign iou_valid  = vld[NSTEP];
  assign iou        = outw;

  // step inputs
  assign sin[0].rem  = {{(AREA_W-INTER_W){1'b0}}, geom.inter};
  assign sin[0].uni  = geom.uni;
  assign sin[0].quo  = '0;
  assign sin[0].full = geom.full;
  assign sin[0].ov   = geom.ov;
  assign vin[0]      = geom_valid;
  for (genvar k = 1; k < NSTEP; k++) begin : g_link
    assign sin[k] = s[k-1];
    assign vin[k] = vld[k-1];
  end

  // quotient bit stages
  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= vin[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && vin[k]) begin
        s[k] <= div_step(sin[k]);
      end
    end
  end

  // output register with the special cases applied
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[NSTEP] <= 1'b0;
    end else if (rdy[NSTEP]) begin
      vld[NSTEP] <= vld[NSTEP-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NSTEP] && vld[NSTEP-1]) begin
      if (s[NSTEP-1].full) begin
        outw.iou_ratio <= RATIO_ONE;
      end else if (s[NSTEP-1].ov) begin
        outw.iou_ratio <= {1'b0, s[NSTEP-1].quo};
      end else begin
        outw.iou_ratio <= '0;
      end
      outw.boxes_overlap <= s[NSTEP-1].ov;
    end
  end

endmodule

[hdl/axis_aligned_box_iou.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_aligned_box_iou: intersection over union of two axis-aligned boxes
// Each word on the box channel carries two boxes as centre, width and
// height in Q12.4. Each word on the iou channel carries the ratio in
// unsigned Q1.16 (truncated) and an overlap flag; touching boxes and
// boxes of zero area give a ratio of 0 with the flag low.
// Both channels use valid and stall; a word moves when valid is high and
// stall is low. Exactly one iou word leaves per box word, in order.
// A word passes 22 registers: 5 geometry stages, 16 divider stages (one
// per quotient bit, each a 36-bit compare and subtract) and the output
// register. Throughput is one box word per cycle while the iou channel
// is not stalled. Every stage holds a valid bit and moves whenever it
// is empty or the stage after it moves, so bubbles close up and input
// words are still taken while a result waits under stall; the box
// channel stalls only when all stages are full.
// Reset clears all valid bits; the pipeline comes up empty.
// ----------------------------------------------------------------------------
module axis_aligned_box_iou
  import aabi_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      box_valid,
  output logic      box_stall,
  input  box_word_t box,
  output logic      iou_valid,
  input  logic      iou_stall,
  output iou_word_t iou
);

  logic       geom_valid;
  logic       geom_stall;
  geom_word_t geom;

  // edges, areas and union
  aabi_geom u_geom (
    .clk        (clk),
    .rst        (rst),
    .box_valid  (box_valid),
    .box_stall  (box_stall),
    .box        (box),
    .geom_valid (geom_valid),
    .geom_stall (geom_stall),
    .geom       (geom)
  );

  // fraction and output register
  aabi_div u_div (
    .clk        (clk),
    .rst        (rst),
    .geom_valid (geom_valid),
    .geom_stall (geom_stall),
    .geom       (geom),
    .iou_valid  (iou_valid),
    .iou_stall  (iou_stall),
    .iou        (iou)
  );

  // no overlap means a zero ratio
  assert property (@(posedge clk) disable iff (rst)
    (iou_valid && !iou.boxes_overlap) |-> (iou.iou_ratio == '0))
    else $error("ratio nonzero without overlap");

  // ratio never exceeds one
  assert property (@(posedge clk) disable iff (rst)
    iou_valid |-> (iou.iou_ratio <= RATIO_ONE))
    else $error("ratio above one");

  // an empty output register lets the whole pipeline move
  assert property (@(posedge clk) disable iff (rst)
    !iou_valid |-> !box_stall)
    else $error("input stalled with empty output");

  // a word taken at the output makes room at the input
  assert property (@(posedge clk) disable iff (rst)
    (iou_valid && !iou_stall) |-> !box_stall)
    else $error("input stalled while output drains");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for axis_aligned_box_iou
// Sends pairs of boxes and predicts each iou word independently, using
// doubled edges, exact 64-bit areas and a truncating division. Every iou
// word that leaves the block is checked in order against that prediction.
// A directed set covers touching, disjoint, zero-area, identical and
// extreme boxes. Random pairs follow, mostly overlapping, in four phases:
// free flow, sender idling, receiver stall, and both together.
// ----------------------------------------------------------------------------
module tb;
  import aabi_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 470;

  // expected iou words, oldest first
  class iou_scoreboard;
    iou_word_t expected_iou[$];
    int        errors = 0;

    // exact iou of one box pair
    function iou_word_t predict_iou(box_word_t b);
      longint x1lo, x1hi, y1lo, y1hi, x2lo, x2hi, y2lo, y2hi;
      longint ixlo, ixhi, iylo, iyhi, inter, uni, q;
      iou_word_t r;
      r = '0;
      x1lo = 2 * longint'(b.pred_center_x) - longint'(b.pred_width);
      x1hi = 2 * longint'(b.pred_center_x) + longint'(b.pred_width);
      y1lo = 2 * longint'(b.pred_center_y) - longint'(b.pred_height);
      y1hi = 2 * longint'(b.pred_center_y) + longint'(b.pred_height);
      x2lo = 2 * longint'(b.tgt_center_x) - longint'(b.tgt_width);
      x2hi = 2 * longint'(b.tgt_center_x) + longint'(b.tgt_width);
      y2lo = 2 * longint'(b.tgt_center_y) - longint'(b.tgt_height);
      y2hi = 2 * longint'(b.tgt_center_y) + longint'(b.tgt_height);
      // touching edges count as apart
      if (x1hi <= x2lo || y1hi <= y2lo || x2hi <= x1lo || y2hi <= y1lo) return r;
      ixlo = (x1lo > x2lo) ? x1lo : x2lo;
      ixhi = (x1hi < x2hi) ? x1hi : x2hi;
      iylo = (y1lo > y2lo) ? y1lo : y2lo;
      iyhi = (y1hi < y2hi) ? y1hi : y2hi;
      if (ixhi <= ixlo || iyhi <= iylo) return r;
      // both areas scaled by four
      inter = (ixhi - ixlo) * (iyhi - iylo);
      uni = 4 * (longint'(b.pred_width) * longint'(b.pred_height)
               + longint'(b.tgt_width) * longint'(b.tgt_height)) - inter;
      if (inter >= uni) q = longint'(1) << RATIO_FRAC_BITS;
      else q = (inter << RATIO_FRAC_BITS) / uni;
      r.iou_ratio = q[RATIO_W-1:0];
      r.boxes_overlap = 1'b1;
      return r;
    endfunction

    function void note_box(box_word_t b);
      expected_iou = {expected_iou, predict_iou(b)};
    endfunction

    function void check_iou(iou_word_t got);
      iou_word_t want;
      if (expected_iou.size() == 0) begin
        $display("%0t: iou word with none expected: ratio %0d overlap %0b",
                 $time, got.iou_ratio, got.boxes_overlap);
        errors++;
        return;
      end
      want = expected_iou.pop_front();
      if (got.iou_ratio !== want.iou_ratio) begin
        $display("%0t: iou_ratio expected %0d got %0d", $time, want.iou_ratio, got.iou_ratio);
        errors++;
      end
      if (got.boxes_overlap !== want.boxes_overlap) begin
        $display("%0t: boxes_overlap expected %0b got %0b",
                 $time, want.boxes_overlap, got.boxes_overlap);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst;
  logic      box_valid;
  logic      box_stall;
  box_word_t box;
  logic      iou_valid;
  logic      iou_stall = 1'b0;
  iou_word_t iou;

  iou_scoreboard sb = new;
  int idle_pct  = 0;
  int stall_pct = 0;
  int boxes_sent   = 0;
  int words_seen   = 0;
  int overlap_seen = 0;
  int cycle_count  = 0;

  axis_aligned_box_iou i_dut (
    .clk       (clk),
    .rst       (rst),
    .box_valid (box_valid),
    .box_stall (box_stall),
    .box       (box),
    .iou_valid (iou_valid),
    .iou_stall (iou_stall),
    .iou       (iou)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver stall
  always @(negedge clk) begin
    iou_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // check each accepted iou word
  always @(posedge clk) begin
    if (!rst && iou_valid && !iou_stall) begin
      sb.check_iou(iou);
      words_seen++;
      if (iou.boxes_overlap) overlap_seen++;
    end
  end

  // one box word, with random gaps ahead of it
  task automatic send_box(input box_word_t b);
    @(negedge clk);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      box_valid <= 1'b0;
      @(negedge clk);
    end
    box_valid <= 1'b1;
    box <= b;
    do @(posedge clk); while (box_stall);
    sb.note_box(b);
    boxes_sent++;
  endtask

  // hold off until every iou word is back
  task automatic drain_iou();
    @(negedge clk);
    box_valid <= 1'b0;
    while (sb.expected_iou.size() != 0) @(posedge clk);
  endtask

  function automatic box_word_t make_pair(int pcx, int pcy, int pw, int ph,
                                          int tcx, int tcy, int tw, int th);
    box_word_t b;
    b.pred_center_x = COORD_BITS'(pcx);
    b.pred_center_y = COORD_BITS'(pcy);
    b.pred_width    = COORD_BITS'(pw);
    b.pred_height   = COORD_BITS'(ph);
    b.tgt_center_x  = COORD_BITS'(tcx);
    b.tgt_center_y  = COORD_BITS'(tcy);
    b.tgt_width     = COORD_BITS'(tw);
    b.tgt_height    = COORD_BITS'(th);
    return b;
  endfunction

  // mostly overlapping pairs, some identical, touching, flat or raw noise
  function automatic box_word_t random_pair();
    box_word_t   b;
    int unsigned kind, span, mask;
    int          sx, sy;
    kind = $urandom_range(99);
    b = {$urandom, $urandom, $urandom, $urandom};
    if (kind < 15) return b;
    span = $urandom_range(16, 1);
    mask = (32'h1 << span) - 1;
    b.pred_width  = COORD_BITS'($urandom & mask);
    b.pred_height = COORD_BITS'($urandom & mask);
    b.tgt_width   = COORD_BITS'($urandom & mask);
    b.tgt_height  = COORD_BITS'($urandom & mask);
    if (kind < 25) begin
      b.tgt_center_x = b.pred_center_x;
      b.tgt_center_y = b.pred_center_y;
      b.tgt_width    = b.pred_width;
      b.tgt_height   = b.pred_height;
      return b;
    end
    sx = int'(b.pred_width) + int'(b.tgt_width);
    sy = int'(b.pred_height) + int'(b.tgt_height);
    if (kind < 35) begin
      // edges meet exactly on x or on y
      b.tgt_width[0]  = b.pred_width[0];
      b.tgt_height[0] = b.pred_height[0];
      sx = int'(b.pred_width) + int'(b.tgt_width);
      sy = int'(b.pred_height) + int'(b.tgt_height);
      if ($urandom_range(1)) begin
        b.tgt_center_x = COORD_BITS'(int'(b.pred_center_x) + sx / 2);
        b.tgt_center_y = COORD_BITS'(int'(b.pred_center_y) + $urandom_range(sy) - sy / 2);
      end else begin
        b.tgt_center_x = COORD_BITS'(int'(b.pred_center_x) + $urandom_range(sx) - sx / 2);
        b.tgt_center_y = COORD_BITS'(int'(b.pred_center_y) - sy / 2);
      end
      return b;
    end
    if (kind < 42) begin
      if ($urandom_range(1)) b.pred_width = '0;
      else b.tgt_height = '0;
    end
    // centre offset within the overlap reach
    b.tgt_center_x = COORD_BITS'(int'(b.pred_center_x)
                                 + (int'($urandom_range(sx)) - sx / 2) / 2);
    b.tgt_center_y = COORD_BITS'(int'(b.pred_center_y)
                                 + (int'($urandom_range(sy)) - sy / 2) / 2);
    return b;
  endfunction

  initial begin
    rst = 1'b1;
    box_valid = 1'b0;
    box = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: zero, identical, extremes, zero area, touching, contained
    send_box(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    send_box(make_pair(0, 0, 16, 16, 0, 0, 16, 16));
    send_box(make_pair(0, 0, 65535, 65535, 0, 0, 65535, 65535));
    send_box(make_pair(-32768, -32768, 65535, 65535, 32767, 32767, 65535, 65535));
    send_box(make_pair(-32768, 32767, 65535, 65535, -32768, 32767, 1, 1));
    send_box(make_pair(0, 0, 0, 32, 0, 0, 64, 64));
    send_box(make_pair(0, 0, 32, 0, 0, 0, 64, 64));
    send_box(make_pair(0, 0, 32, 32, 32, 0, 32, 32));
    send_box(make_pair(0, 0, 32, 32, 0, 32, 32, 32));
    send_box(make_pair(-1000, -1000, 10, 10, 1000, 1000, 10, 10));
    send_box(make_pair(0, 0, 160, 160, 8, -8, 16, 16));
    send_box(make_pair(8, -8, 16, 16, 0, 0, 160, 160));
    send_box(make_pair(0, 0, 32, 32, 8, 8, 32, 32));
    send_box(make_pair(1, -1, 1, 1, 1, -1, 1, 1));
    send_box(make_pair(0, 0, 1, 1, 0, 0, 1, 3));
    send_box(make_pair(32767, -32768, 65535, 0, 32767, -32768, 65535, 1));
    send_box(make_pair(0, 0, 65535, 16, 0, 0, 16, 65535));
    send_box(make_pair(-1, -1, 65535, 65535, -2, 1, 65534, 65533));
    send_box(make_pair(0, 0, 32, 32, 31, 0, 32, 32));
    send_box(make_pair(-100, 50, 200, 300, -120, 70, 150, 180));
    drain_iou();

    // random phases: free flow, sender gaps, receiver stall, both
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = (phase == 1) ? 53 : (phase == 3) ? 34 : 0;
      stall_pct = (phase == 2) ? 53 : (phase == 3) ? 34 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) send_box(random_pair());
      drain_iou();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.expected_iou.size() != 0) begin
      $display("%0t: %0d iou words never arrived", $time, sb.expected_iou.size());
      sb.errors++;
    end
    $display("sent %0d box pairs in directed and four random phases", boxes_sent);
    $display("checked %0d iou words, %0d overlapping, %0d errors",
             words_seen, overlap_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
